// ----- hw/rtl/tet10_shape_function_eval_unit_defines.svh -----
// Assertion macros shared by the Tet10 shape function unit.
`ifndef TET10_SHAPE_FUNCTION_EVAL_UNIT_DEFINES_SVH
`define TET10_SHAPE_FUNCTION_EVAL_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define T10SF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define T10SF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/t10sf_pkg.sv -----
`timescale 1ns / 1ps
package t10sf_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int VAL_W     = 64;
    localparam int BARY_W    = 17;
    localparam int NODE_W    = 4;
    localparam int SHAPE_W   = 24;
    localparam int NUM_NODES = 10;
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NUM_NODES - 1);

    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [VAL_W-1:0] SHAPE_MAX = VAL_W'((64'd1 << (SHAPE_W - 1)) - 64'd1);
    localparam logic [VAL_W-1:0] SHAPE_MIN = ~SHAPE_MAX;

    // Register file layout: coordinates first, then working values.
    localparam int RF_AW    = 7;
    localparam int RF_DEPTH = 1 << RF_AW;
    localparam int XI_BASE  = 30;
    localparam int WQ_BASE  = 34;
    localparam int JAC_BASE = 38;
    localparam int D_BASE   = 50;
    localparam int N_BASE   = 68;
    localparam int T0       = 86;
    localparam int T1       = 87;
    localparam int T2       = 88;
    localparam int T3       = 89;
    localparam int CF_BASE  = 90;
    localparam int CD_BASE  = 102;

    localparam int PROG_LEN = 320;
    localparam int PC_W     = $clog2(PROG_LEN);

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_NEG, OP_SCL2, OP_SCL4, OP_SUBQ, OP_SUBONE,
        OP_MUL, OP_EMIT, OP_END
    } t_op;

    typedef enum logic [2:0] {
        WS_RF, WS_SHP, WS_DX, WS_DY, WS_DZ, WS_DET
    } t_wsel;

    typedef struct packed {
        t_op              op;
        logic [RF_AW-1:0] ra;
        logic [RF_AW-1:0] rb;
        logic [RF_AW-1:0] rd;
        t_wsel            ws;
    } t_uop;

    typedef t_uop [PROG_LEN-1:0] t_prog;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_XI, S_FETCH, S_READ, S_EXEC, S_MUL, S_EMIT
    } t_state;

    typedef struct packed {
        t_uop       uop;
        logic       capture;
        logic       ld_we;
        logic       xi_we;
        logic [1:0] cnt;
        logic       exec;
        logic       mul_start;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic out_free;
    } t_status;

    localparam int CORNER_NODES [4][4] = '{
        '{0, 4, 6, 7}, '{4, 1, 5, 8}, '{6, 5, 2, 9}, '{7, 8, 9, 3}};
    localparam int EDGE_PAIR [6][2] = '{
        '{0, 1}, '{1, 2}, '{2, 0}, '{0, 3}, '{1, 3}, '{2, 3}};
    // Cofactor terms: axes p, q and four index pairs. The first twelve rows
    // give the derivative cofactors, the last three feed the determinant.
    localparam int COF_TAB [15][10] = '{
        '{1, 2, 4, 2, 3, 2, 3, 2, 4, 2},
        '{1, 2, 3, 1, 4, 3, 3, 4, 1, 3},
        '{1, 2, 2, 4, 1, 4, 1, 4, 2, 4},
        '{1, 2, 1, 3, 2, 1, 1, 2, 3, 1},
        '{0, 2, 3, 2, 4, 2, 4, 2, 3, 2},
        '{0, 2, 4, 3, 3, 1, 1, 3, 3, 4},
        '{0, 2, 1, 4, 2, 4, 2, 4, 1, 4},
        '{0, 2, 2, 1, 1, 3, 3, 1, 1, 2},
        '{0, 1, 4, 2, 3, 2, 3, 2, 4, 2},
        '{0, 1, 3, 1, 4, 3, 3, 4, 1, 3},
        '{0, 1, 2, 4, 1, 4, 1, 4, 2, 4},
        '{0, 1, 1, 3, 2, 1, 1, 2, 3, 1},
        '{1, 2, 2, 3, 3, 4, 3, 4, 2, 3},
        '{1, 2, 3, 4, 1, 2, 1, 2, 3, 4},
        '{1, 2, 1, 2, 2, 3, 2, 3, 1, 2}};

    function automatic t_uop mk(t_op op, int ra, int rb, int rd, t_wsel ws);
        t_uop u;
        u.op = op;
        u.ra = RF_AW'(ra);
        u.rb = RF_AW'(rb);
        u.rd = RF_AW'(rd);
        u.ws = ws;
        return u;
    endfunction

    // Address of the Jacobian difference J[axis][i] - J[axis][j].
    function automatic int jd_addr(int axis, int i, int j);
        int lo;
        int hi;
        int p;
        lo = (i < j) ? i : j;
        hi = (i < j) ? j : i;
        p  = (lo == 1) ? hi - 2 : ((lo == 2) ? hi : 5);
        return (i < j) ? D_BASE + axis * 6 + p : N_BASE + axis * 6 + p;
    endfunction

    function automatic t_wsel axis_ws(int a);
        t_wsel w;
        case (a)
            0: w = WS_DX;
            1: w = WS_DY;
            default: w = WS_DZ;
        endcase
        return w;
    endfunction

    function automatic t_uop cof_op(int k, int sel, int dst);
        t_uop u;
        case (sel)
            0: u = mk(OP_MUL, jd_addr(COF_TAB[k][0], COF_TAB[k][2], COF_TAB[k][3]),
                      jd_addr(COF_TAB[k][1], COF_TAB[k][4], COF_TAB[k][5]), T2, WS_RF);
            1: u = mk(OP_MUL, jd_addr(COF_TAB[k][0], COF_TAB[k][6], COF_TAB[k][7]),
                      jd_addr(COF_TAB[k][1], COF_TAB[k][8], COF_TAB[k][9]), T3, WS_RF);
            default: u = mk(OP_SUB, T2, T3, dst, WS_RF);
        endcase
        return u;
    endfunction

    // Microprogram for one evaluation, built at elaboration.
    function automatic t_prog build_prog();
        t_prog p;
        int    n;
        int    k;
        int    a;
        int    i;
        int    j;
        int    s;
        int    w;
        int    c;
        int    pp;
        int    qq;
        for (k = 0; k < PROG_LEN; k++) begin
            p[k] = mk(OP_END, 0, 0, 0, WS_RF);
        end
        n = 0;
        for (i = 0; i < 4; i++) begin
            p[n] = mk(OP_SUBQ, XI_BASE + i, 0, WQ_BASE + i, WS_RF);
            n++;
        end
        for (a = 0; a < 3; a++) begin
            for (i = 0; i < 4; i++) begin
                for (j = 0; j < 4; j++) begin
                    w = (j == i) ? WQ_BASE + j : XI_BASE + j;
                    c = CORNER_NODES[i][j] * 3 + a;
                    if (j == 0) begin
                        p[n] = mk(OP_MUL, c, w, T0, WS_RF);
                        n++;
                    end else begin
                        p[n] = mk(OP_MUL, c, w, T1, WS_RF);
                        n++;
                        p[n] = mk(OP_ADD, T0, T1, T0, WS_RF);
                        n++;
                    end
                end
                p[n] = mk(OP_SCL4, T0, 0, JAC_BASE + a * 4 + i, WS_RF);
                n++;
            end
        end
        for (a = 0; a < 3; a++) begin
            for (i = 1; i < 4; i++) begin
                for (j = i + 1; j < 5; j++) begin
                    p[n] = mk(OP_SUB, JAC_BASE + a * 4 + i - 1, JAC_BASE + a * 4 + j - 1,
                              jd_addr(a, i, j), WS_RF);
                    n++;
                    p[n] = mk(OP_NEG, jd_addr(a, i, j), 0, jd_addr(a, j, i), WS_RF);
                    n++;
                end
            end
        end
        for (k = 0; k < 3; k++) begin
            for (s = 0; s < 3; s++) begin
                p[n] = cof_op(12 + k, s, CD_BASE + k);
                n++;
            end
        end
        p[n] = mk(OP_MUL, jd_addr(0, 2, 1), CD_BASE, T0, WS_RF);
        n++;
        p[n] = mk(OP_MUL, jd_addr(0, 3, 2), CD_BASE + 1, T1, WS_RF);
        n++;
        p[n] = mk(OP_ADD, T0, T1, T0, WS_RF);
        n++;
        p[n] = mk(OP_MUL, jd_addr(0, 4, 3), CD_BASE + 2, T1, WS_RF);
        n++;
        p[n] = mk(OP_ADD, T0, T1, 0, WS_DET);
        n++;
        for (k = 0; k < 12; k++) begin
            for (s = 0; s < 3; s++) begin
                p[n] = cof_op(k, s, CF_BASE + k);
                n++;
            end
        end
        for (i = 0; i < 4; i++) begin
            p[n] = mk(OP_SCL2, XI_BASE + i, 0, T0, WS_RF);
            n++;
            p[n] = mk(OP_SUBONE, T0, 0, T0, WS_RF);
            n++;
            p[n] = mk(OP_MUL, XI_BASE + i, T0, 0, WS_SHP);
            n++;
            p[n] = mk(OP_SCL4, XI_BASE + i, 0, T1, WS_RF);
            n++;
            p[n] = mk(OP_SUBONE, T1, 0, T1, WS_RF);
            n++;
            for (a = 0; a < 3; a++) begin
                p[n] = mk(OP_MUL, T1, CF_BASE + a * 4 + i, 0, axis_ws(a));
                n++;
            end
            p[n] = mk(OP_EMIT, i, 0, 0, WS_RF);
            n++;
        end
        for (k = 0; k < 6; k++) begin
            pp = EDGE_PAIR[k][0];
            qq = EDGE_PAIR[k][1];
            p[n] = mk(OP_SCL4, XI_BASE + pp, 0, T0, WS_RF);
            n++;
            p[n] = mk(OP_MUL, T0, XI_BASE + qq, 0, WS_SHP);
            n++;
            for (a = 0; a < 3; a++) begin
                p[n] = mk(OP_MUL, XI_BASE + pp, CF_BASE + a * 4 + qq, T2, WS_RF);
                n++;
                p[n] = mk(OP_MUL, XI_BASE + qq, CF_BASE + a * 4 + pp, T3, WS_RF);
                n++;
                p[n] = mk(OP_ADD, T2, T3, T2, WS_RF);
                n++;
                p[n] = mk(OP_SCL4, T2, 0, 0, axis_ws(a));
                n++;
            end
            p[n] = mk(OP_EMIT, 4 + k, 0, 0, WS_RF);
            n++;
        end
        return p;
    endfunction

    localparam t_prog PROG = build_prog();

endpackage

// ----- hw/rtl/t10sf_mul.sv -----
`timescale 1ns / 1ps
module t10sf_mul #(
    parameter int FRAC_BITS = t10sf_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_result
);
    import t10sf_pkg::*;

    localparam int PW = 2 * VAL_W;
    localparam logic [PW-1:0] REM_MASK = (PW'(1) << FRAC_BITS) - PW'(1);

    logic [2:0]       r_cnt;
    logic [VAL_W-1:0] r_ua;
    logic [VAL_W-1:0] r_ub;
    logic             r_neg;
    logic [PW-1:0]    r_pp;
    logic [PW-1:0]    r_acc;
    logic [PW-1:0]    r_q;

    logic [1:0]  sel;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] prod;
    logic [PW-1:0] pp_shifted;
    logic [PW-1:0] quo;

    // Four 32x32 partial products, one per cycle, each registered before
    // it is accumulated.
    always_comb begin
        sel        = 2'(r_cnt - 3'd1);
        op_a       = sel[1] ? r_ua[63:32] : r_ua[31:0];
        op_b       = sel[0] ? r_ub[63:32] : r_ub[31:0];
        prod       = 64'(op_a) * 64'(op_b);
        pp_shifted = PW'(prod) << (32 * (32'(sel[1]) + 32'(sel[0])));
        quo        = r_acc >> FRAC_BITS;
        if (r_neg && ((r_acc & REM_MASK) != '0)) begin
            quo = quo + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_start) begin
            r_cnt <= 3'd1;
        end else if (r_cnt != 3'd0) begin
            r_cnt <= r_cnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= i_a[63] ? 64'd0 - i_a : i_a;
            r_ub  <= i_b[63] ? 64'd0 - i_b : i_b;
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= '0;
        end else begin
            if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                r_pp <= pp_shifted;
            end
            if (r_cnt >= 3'd2 && r_cnt <= 3'd5) begin
                r_acc <= r_acc + r_pp;
            end
            if (r_cnt == 3'd6) begin
                r_q <= quo;
            end
        end
    end

    always_comb begin
        o_done = (r_cnt == 3'd7);
        if (r_q[PW-1:VAL_W-1] != '0) begin
            o_result = r_neg ? VAL_MIN : VAL_MAX;
        end else begin
            o_result = r_neg ? 64'd0 - r_q[63:0] : r_q[63:0];
        end
    end

endmodule

// ----- hw/rtl/t10sf_dpath.sv -----
`timescale 1ns / 1ps
module t10sf_dpath #(
    parameter int COORD_BITS = t10sf_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = t10sf_pkg::FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t10sf_pkg::t_cmd         i_cmd,
    output t10sf_pkg::t_status      o_status,
    input  logic [3:0]              i_node_index,
    input  logic [COORD_BITS-1:0]   i_coord_x,
    input  logic [COORD_BITS-1:0]   i_coord_y,
    input  logic [COORD_BITS-1:0]   i_coord_z,
    input  logic [16:0]             i_bary_one,
    input  logic [16:0]             i_bary_two,
    input  logic [16:0]             i_bary_three,
    input  logic [16:0]             i_bary_four,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output logic [3:0]              o_out_node,
    output logic [23:0]             o_shape_value,
    output logic [63:0]             o_deriv_x,
    output logic [63:0]             o_deriv_y,
    output logic [63:0]             o_deriv_z,
    output logic [63:0]             o_jacobian_det,
    output logic                    o_last_row
);
    import t10sf_pkg::*;

    localparam logic [VAL_W-1:0] ONE_Q     = VAL_W'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0] QUARTER_Q = ONE_Q >> 2;

    function automatic logic [VAL_W-1:0] sat_add(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            return a[VAL_W-1] ? VAL_MIN : VAL_MAX;
        end
        return s[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] sat_sub(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            return a[VAL_W-1] ? VAL_MIN : VAL_MAX;
        end
        return s[VAL_W-1:0];
    endfunction

    logic [VAL_W-1:0] r_rf [RF_DEPTH];

    logic [NODE_W-1:0]     r_node;
    logic [COORD_BITS-1:0] r_cx;
    logic [COORD_BITS-1:0] r_cy;
    logic [COORD_BITS-1:0] r_cz;
    logic [BARY_W-1:0]     r_bary [4];
    logic [VAL_W-1:0]      r_a;
    logic [VAL_W-1:0]      r_b;
    logic [VAL_W-1:0]      r_shp;
    logic [VAL_W-1:0]      r_dx;
    logic [VAL_W-1:0]      r_dy;
    logic [VAL_W-1:0]      r_dz;
    logic [VAL_W-1:0]      r_det;

    logic                  r_ovalid;
    logic [NODE_W-1:0]     r_onode;
    logic [SHAPE_W-1:0]    r_oshape;
    logic [VAL_W-1:0]      r_odx;
    logic [VAL_W-1:0]      r_ody;
    logic [VAL_W-1:0]      r_odz;
    logic [VAL_W-1:0]      r_odet;
    logic                  r_olast;

    logic                  mul_done;
    logic [VAL_W-1:0]      mul_res;
    logic [VAL_W-1:0]      alu;
    logic [VAL_W-1:0]      wr_val;
    logic                  wr_any;
    logic                  rf_we;
    logic [RF_AW-1:0]      rf_waddr;
    logic [VAL_W-1:0]      rf_wdata;
    logic [COORD_BITS-1:0] coord_sel;
    logic [SHAPE_W-1:0]    shape_sat;

    t10sf_mul #(
        .FRAC_BITS(FRAC_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.mul_start),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_node    <= i_node_index;
            r_cx      <= i_coord_x;
            r_cy      <= i_coord_y;
            r_cz      <= i_coord_z;
            r_bary[0] <= i_bary_one;
            r_bary[1] <= i_bary_two;
            r_bary[2] <= i_bary_three;
            r_bary[3] <= i_bary_four;
        end
    end

    always_comb begin
        case (i_cmd.uop.op)
            OP_ADD:    alu = sat_add(r_a, r_b);
            OP_SUB:    alu = sat_sub(r_a, r_b);
            OP_NEG:    alu = (r_a == VAL_MIN) ? VAL_MAX : VAL_W'(0) - r_a;
            OP_SCL2: begin
                if (r_a[VAL_W-1] != r_a[VAL_W-2]) begin
                    alu = r_a[VAL_W-1] ? VAL_MIN : VAL_MAX;
                end else begin
                    alu = r_a << 1;
                end
            end
            OP_SCL4: begin
                if (r_a[VAL_W-1:VAL_W-3] != 3'b000 && r_a[VAL_W-1:VAL_W-3] != 3'b111) begin
                    alu = r_a[VAL_W-1] ? VAL_MIN : VAL_MAX;
                end else begin
                    alu = r_a << 2;
                end
            end
            OP_SUBQ:   alu = sat_sub(r_a, QUARTER_Q);
            OP_SUBONE: alu = sat_sub(r_a, ONE_Q);
            default:   alu = r_a;
        endcase
    end

    always_comb begin
        wr_any = i_cmd.exec | mul_done;
        wr_val = mul_done ? mul_res : alu;
        case (i_cmd.cnt)
            2'd0:    coord_sel = r_cx;
            2'd1:    coord_sel = r_cy;
            default: coord_sel = r_cz;
        endcase
        rf_we    = 1'b0;
        rf_waddr = i_cmd.uop.rd;
        rf_wdata = wr_val;
        if (i_cmd.ld_we) begin
            // Loads to a node index beyond the last node are dropped.
            rf_we    = (r_node < NODE_W'(NUM_NODES));
            rf_waddr = RF_AW'(r_node) * RF_AW'(3) + RF_AW'(i_cmd.cnt);
            rf_wdata = {{(VAL_W-COORD_BITS){coord_sel[COORD_BITS-1]}}, coord_sel};
        end else if (i_cmd.xi_we) begin
            rf_we    = 1'b1;
            rf_waddr = RF_AW'(XI_BASE) + RF_AW'(i_cmd.cnt);
            rf_wdata = VAL_W'(r_bary[i_cmd.cnt]);
        end else if (wr_any && i_cmd.uop.ws == WS_RF) begin
            rf_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_waddr] <= rf_wdata;
        end
        r_a <= r_rf[i_cmd.uop.ra];
        r_b <= r_rf[i_cmd.uop.rb];
    end

    always_ff @(posedge i_clk) begin
        if (wr_any) begin
            case (i_cmd.uop.ws)
                WS_SHP:  r_shp <= wr_val;
                WS_DX:   r_dx  <= wr_val;
                WS_DY:   r_dy  <= wr_val;
                WS_DZ:   r_dz  <= wr_val;
                WS_DET:  r_det <= wr_val;
                default: ;
            endcase
        end
    end

    always_comb begin
        if ($signed(r_shp) > $signed(SHAPE_MAX)) begin
            shape_sat = SHAPE_MAX[SHAPE_W-1:0];
        end else if ($signed(r_shp) < $signed(SHAPE_MIN)) begin
            shape_sat = SHAPE_MIN[SHAPE_W-1:0];
        end else begin
            shape_sat = r_shp[SHAPE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_onode  <= i_cmd.uop.ra[NODE_W-1:0];
            r_oshape <= shape_sat;
            r_odx    <= r_dx;
            r_ody    <= r_dy;
            r_odz    <= r_dz;
            r_odet   <= r_det;
            r_olast  <= (i_cmd.uop.ra[NODE_W-1:0] == LAST_NODE);
        end
    end

    assign o_status.mul_done = mul_done;
    assign o_status.out_free = !r_ovalid || !i_out_stall;

    assign o_out_valid    = r_ovalid;
    assign o_out_node     = r_onode;
    assign o_shape_value  = r_oshape;
    assign o_deriv_x      = r_odx;
    assign o_deriv_y      = r_ody;
    assign o_deriv_z      = r_odz;
    assign o_jacobian_det = r_odet;
    assign o_last_row     = r_olast;

endmodule

// ----- hw/rtl/t10sf_ctrl.sv -----
`timescale 1ns / 1ps
module t10sf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_mode,
    input  t10sf_pkg::t_status i_status,
    output t10sf_pkg::t_cmd    o_cmd,
    output logic               o_in_stall
);
    import t10sf_pkg::*;

    t_state          r_state;
    t_state          n_state;
    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    logic [1:0]      r_cnt;
    logic [1:0]      n_cnt;
    t_uop            r_uop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FETCH) begin
            r_uop <= PROG[r_pc];
        end
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                n_cnt = 2'd0;
                if (i_in_valid) begin
                    n_state = i_mode ? S_XI : S_LOAD;
                end
            end
            S_LOAD: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd2) begin
                    n_state = S_IDLE;
                end
            end
            S_XI: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = S_FETCH;
                    n_pc    = '0;
                end
            end
            S_FETCH: n_state = S_READ;
            S_READ: begin
                case (r_uop.op)
                    OP_END:  n_state = S_IDLE;
                    OP_EMIT: n_state = S_EMIT;
                    default: n_state = S_EXEC;
                endcase
            end
            S_EXEC: begin
                if (r_uop.op == OP_MUL) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_FETCH;
                    n_pc    = r_pc + PC_W'(1);
                end
            end
            S_MUL: begin
                if (i_status.mul_done) begin
                    n_state = S_FETCH;
                    n_pc    = r_pc + PC_W'(1);
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = S_FETCH;
                    n_pc    = r_pc + PC_W'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.uop       = r_uop;
        o_cmd.cnt       = r_cnt;
        o_cmd.capture   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.ld_we     = (r_state == S_LOAD);
        o_cmd.xi_we     = (r_state == S_XI);
        o_cmd.exec      = (r_state == S_EXEC) && (r_uop.op != OP_MUL);
        o_cmd.mul_start = (r_state == S_EXEC) && (r_uop.op == OP_MUL);
        o_cmd.emit      = (r_state == S_EMIT) && i_status.out_free;
        o_in_stall      = (r_state != S_IDLE);
    end

endmodule

// ----- hw/rtl/tet10_shape_function_eval_unit.sv -----
// Ten-node quadratic tetrahedron shape function unit, signed fixed point.
// Input channel (i_in_valid / o_in_stall): a word with i_mode low loads the
// x, y and z coordinates of node i_node_index; indexes above nine are ignored.
// A word with i_mode high evaluates at the four barycentric coordinates.
// Output channel (o_out_valid / i_out_stall): an evaluation returns ten words,
// nodes zero to nine in order, with o_last_row set on the tenth.
// A load writes the x, y and z coordinates in turn before the next word is accepted.
// An evaluation runs the microprogram one step at a time on a single shared
// multiplier and adder: 139 steps are products, the other 173 steps are
// additions, subtractions, negations, scalings and row emits.
// Only one word is worked on at a time; o_in_stall is high until it is done.
// Rows leave through an output register, so a stalled row holds while the
// next one is computed; the sequencer waits only when a second row is ready.
// Reset (synchronous, active low) empties the output register and returns
// the sequencer to idle. Coordinates are not cleared and must be loaded
// before the first evaluation.
`timescale 1ns / 1ps
`include "tet10_shape_function_eval_unit_defines.svh"
module tet10_shape_function_eval_unit #(
    parameter int COORD_BITS = t10sf_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = t10sf_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_mode,
    input  logic [3:0]            i_node_index,
    input  logic [COORD_BITS-1:0] i_coord_x,
    input  logic [COORD_BITS-1:0] i_coord_y,
    input  logic [COORD_BITS-1:0] i_coord_z,
    input  logic [16:0]           i_bary_one,
    input  logic [16:0]           i_bary_two,
    input  logic [16:0]           i_bary_three,
    input  logic [16:0]           i_bary_four,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [3:0]            o_out_node,
    output logic [23:0]           o_shape_value,
    output logic [63:0]           o_deriv_x,
    output logic [63:0]           o_deriv_y,
    output logic [63:0]           o_deriv_z,
    output logic [63:0]           o_jacobian_det,
    output logic                  o_last_row
);
    import t10sf_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    load_take;
    logic    row_take;

    // The controller walks the microprogram; the datapath holds the
    // coordinate and working register file, the saturating adder and the
    // multi-cycle multiplier.
    t10sf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    t10sf_dpath #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_node_index   (i_node_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_bary_one     (i_bary_one),
        .i_bary_two     (i_bary_two),
        .i_bary_three   (i_bary_three),
        .i_bary_four    (i_bary_four),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_node     (o_out_node),
        .o_shape_value  (o_shape_value),
        .o_deriv_x      (o_deriv_x),
        .o_deriv_y      (o_deriv_y),
        .o_deriv_z      (o_deriv_z),
        .o_jacobian_det (o_jacobian_det),
        .o_last_row     (o_last_row)
    );

    // A load word is taken, or a row is taken, in this cycle.
    assign load_take = i_in_valid && !o_in_stall && !i_mode;
    assign row_take  = o_out_valid && !i_out_stall;

    // A new row only appears while an evaluation is still in progress.
    `T10SF_ASSERT_IMPL(a_row_while_busy, $rose(o_out_valid), o_in_stall, "row outside evaluation")

    // A load word never produces a row.
    `T10SF_ASSERT_NEXT(a_load_no_row, load_take && !o_out_valid, !o_out_valid, "row after load")

    // Once a row other than the last is taken, more rows are still pending.
    `T10SF_ASSERT_NEXT(a_more_rows, row_take && !o_last_row, o_in_stall, "idle before last row")

endmodule

// ----- dv/tet10_shape_function_eval_unit_tb.sv -----
`timescale 1ns / 1ps
module tet10_shape_function_eval_unit_tb;
    import t10sf_pkg::*;

    // One expected result word: a single node row of an evaluation.
    typedef struct {
        logic [3:0]  node;
        logic [23:0] shape;
        logic [63:0] dx;
        logic [63:0] dy;
        logic [63:0] dz;
        logic [63:0] det;
        logic        last;
    } node_row_t;

    typedef logic signed [127:0] wide_t;

    localparam longint Q_ONE     = 64'sd65536;
    localparam longint Q_QUARTER = 64'sd16384;
    localparam longint L_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint L_MIN     = 64'sh8000_0000_0000_0000;
    localparam int     IDLE_LIMIT = 30000;
    localparam int     LONG_HOLD  = 4000;

    // The scoreboard keeps its own copy of the coordinate store and turns every
    // accepted evaluate word into ten expected node rows.
    class tet10_scoreboard;
        longint    coords[30];
        node_row_t row_q[$];
        int        errors;

        function new();
            errors = 0;
            foreach (coords[k]) coords[k] = 0;
        endfunction

        function longint clamp64(wide_t v);
            if (v > wide_t'(L_MAX)) return L_MAX;
            if (v < wide_t'(L_MIN)) return L_MIN;
            return longint'(v);
        endfunction

        function longint q_add(longint a, longint b);
            return clamp64(wide_t'(a) + wide_t'(b));
        endfunction

        function longint q_sub(longint a, longint b);
            return clamp64(wide_t'(a) - wide_t'(b));
        endfunction

        function longint q_neg(longint a);
            return clamp64(-wide_t'(a));
        endfunction

        function longint q_scale(longint a, longint k);
            return clamp64(wide_t'(a) * wide_t'(k));
        endfunction

        // Exact product, floor shift by the fraction width, then clamp.
        function longint q_mul(longint a, longint b);
            wide_t p;
            p = wide_t'(a) * wide_t'(b);
            return clamp64(p >>> 16);
        endfunction

        // Difference of Jacobian entries, 1-based, with the reversed order
        // formed as the negated forward difference.
        function longint jac_diff(longint jm[3][4], int axis, int i, int j);
            if (i < j) return q_sub(jm[axis][i-1], jm[axis][j-1]);
            return q_neg(q_sub(jm[axis][j-1], jm[axis][i-1]));
        endfunction

        function longint cofactor(longint jm[3][4], int r);
            return q_sub(
                q_mul(jac_diff(jm, COF_TAB[r][0], COF_TAB[r][2], COF_TAB[r][3]),
                      jac_diff(jm, COF_TAB[r][1], COF_TAB[r][4], COF_TAB[r][5])),
                q_mul(jac_diff(jm, COF_TAB[r][0], COF_TAB[r][6], COF_TAB[r][7]),
                      jac_diff(jm, COF_TAB[r][1], COF_TAB[r][8], COF_TAB[r][9])));
        endfunction

        function void note_word(logic mode, logic [3:0] idx, logic [31:0] cx,
                                logic [31:0] cy, logic [31:0] cz, logic [16:0] b1,
                                logic [16:0] b2, logic [16:0] b3, logic [16:0] b4);
            longint    xi[4];
            longint    jm[3][4];
            longint    cf[3][4];
            longint    dn[3][10];
            longint    shp[10];
            longint    acc;
            longint    w;
            longint    det;
            longint    s;
            int        p;
            int        q;
            node_row_t r;
            if (!mode) begin
                if (idx <= 9) begin
                    coords[idx*3]   = longint'($signed(cx));
                    coords[idx*3+1] = longint'($signed(cy));
                    coords[idx*3+2] = longint'($signed(cz));
                end
                return;
            end
            xi[0] = b1; xi[1] = b2; xi[2] = b3; xi[3] = b4;
            for (int a = 0; a < 3; a++) begin
                for (int i = 0; i < 4; i++) begin
                    acc = 0;
                    for (int j = 0; j < 4; j++) begin
                        w = (j == i) ? q_sub(xi[j], Q_QUARTER) : xi[j];
                        w = q_mul(coords[CORNER_NODES[i][j]*3 + a], w);
                        acc = (j == 0) ? w : q_add(acc, w);
                    end
                    jm[a][i] = q_scale(acc, 4);
                end
            end
            det = q_add(q_add(q_mul(jac_diff(jm, 0, 2, 1), cofactor(jm, 12)),
                              q_mul(jac_diff(jm, 0, 3, 2), cofactor(jm, 13))),
                        q_mul(jac_diff(jm, 0, 4, 3), cofactor(jm, 14)));
            for (int k = 0; k < 12; k++) cf[k/4][k%4] = cofactor(jm, k);
            for (int i = 0; i < 4; i++) begin
                shp[i] = q_mul(xi[i], q_sub(q_scale(xi[i], 2), Q_ONE));
                for (int a = 0; a < 3; a++)
                    dn[a][i] = q_mul(q_sub(q_scale(xi[i], 4), Q_ONE), cf[a][i]);
            end
            for (int k = 0; k < 6; k++) begin
                p = EDGE_PAIR[k][0];
                q = EDGE_PAIR[k][1];
                shp[4+k] = q_mul(q_scale(xi[p], 4), xi[q]);
                for (int a = 0; a < 3; a++)
                    dn[a][4+k] = q_scale(q_add(q_mul(xi[p], cf[a][q]),
                                               q_mul(xi[q], cf[a][p])), 4);
            end
            for (int k = 0; k < 10; k++) begin
                s = shp[k];
                if (s > 8388607) s = 8388607;
                if (s < -8388608) s = -8388608;
                r.node  = 4'(k);
                r.shape = s[23:0];
                r.dx    = dn[0][k];
                r.dy    = dn[1][k];
                r.dz    = dn[2][k];
                r.det   = det;
                r.last  = (k == 9);
                row_q.push_back(r);
            end
        endfunction

        function void field_cmp(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                errors++;
                $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
            end
        endfunction

        function void check_row(node_row_t got);
            node_row_t e;
            if (row_q.size() == 0) begin
                errors++;
                $display("%0t unexpected row: node %0d", $time, got.node);
                return;
            end
            e = row_q.pop_front();
            field_cmp("out_node", 64'(e.node), 64'(got.node));
            field_cmp("shape_value", 64'(e.shape), 64'(got.shape));
            field_cmp("deriv_x", e.dx, got.dx);
            field_cmp("deriv_y", e.dy, got.dy);
            field_cmp("deriv_z", e.dz, got.dz);
            field_cmp("jacobian_det", e.det, got.det);
            field_cmp("last_row", 64'(e.last), 64'(got.last));
        endfunction

        function int pending();
            return row_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_mode;
    logic [3:0]  i_node_index;
    logic [31:0] i_coord_x;
    logic [31:0] i_coord_y;
    logic [31:0] i_coord_z;
    logic [16:0] i_bary_one;
    logic [16:0] i_bary_two;
    logic [16:0] i_bary_three;
    logic [16:0] i_bary_four;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [3:0]  o_out_node;
    logic [23:0] o_shape_value;
    logic [63:0] o_deriv_x;
    logic [63:0] o_deriv_y;
    logic [63:0] o_deriv_z;
    logic [63:0] o_jacobian_det;
    logic        o_last_row;

    tet10_scoreboard sb;
    bit              hold_req;
    int              idle_cycles;

    tet10_shape_function_eval_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_node_index   (i_node_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_coord_z      (i_coord_z),
        .i_bary_one     (i_bary_one),
        .i_bary_two     (i_bary_two),
        .i_bary_three   (i_bary_three),
        .i_bary_four    (i_bary_four),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_node     (o_out_node),
        .o_shape_value  (o_shape_value),
        .o_deriv_x      (o_deriv_x),
        .o_deriv_y      (o_deriv_y),
        .o_deriv_z      (o_deriv_z),
        .o_jacobian_det (o_jacobian_det),
        .o_last_row     (o_last_row)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 80) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 10);
        return $urandom_range(20, 200);
    endfunction

    // Words are observed at the same edge the block takes them, so the
    // prediction and the check both see the values the block saw.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_word(i_mode, i_node_index, i_coord_x, i_coord_y, i_coord_z,
                             i_bary_one, i_bary_two, i_bary_three, i_bary_four);
            if (o_out_valid && !i_out_stall)
                sb.check_row('{o_out_node, o_shape_value, o_deriv_x, o_deriv_y,
                               o_deriv_z, o_jacobian_det, o_last_row});
        end
    end

    // Watchdog: any stretch this long with no word moving on either side
    // means the block has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stall stretches, plus one long hold-off on request so
    // the output register and then the input side back up.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
                repeat (pick_gap()) @(posedge i_clk);
            end
        end
    end

    // Offer one word and hold it until the block takes it, then idle for gap.
    task automatic send_word(logic mode, logic [3:0] idx, logic [31:0] cx,
                             logic [31:0] cy, logic [31:0] cz, logic [16:0] b1,
                             logic [16:0] b2, logic [16:0] b3, logic [16:0] b4,
                             int gap);
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_node_index <= idx;
        i_coord_x    <= cx;
        i_coord_y    <= cy;
        i_coord_z    <= cz;
        i_bary_one   <= b1;
        i_bary_two   <= b2;
        i_bary_three <= b3;
        i_bary_four  <= b4;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // A load word carries random barycentric bits too; the block ignores them.
    task automatic load_node(logic [3:0] idx, logic [31:0] cx, logic [31:0] cy,
                             logic [31:0] cz, int gap);
        send_word(1'b0, idx, cx, cy, cz, 17'($urandom), 17'($urandom),
                  17'($urandom), 17'($urandom), gap);
    endtask

    task automatic evaluate(logic [16:0] b1, logic [16:0] b2, logic [16:0] b3,
                            logic [16:0] b4, int gap);
        send_word(1'b1, 4'($urandom), $urandom, $urandom, $urandom, b1, b2, b3, b4, gap);
    endtask

    // Loads a right-angled tetrahedron with legs of two, edge nodes at the midpoints, scaled.
    task automatic load_unit_tet(int scale);
        logic signed [31:0] cx[10];
        logic signed [31:0] cy[10];
        logic signed [31:0] cz[10];
        cx = '{0, 2, 0, 0, 1, 1, 0, 0, 1, 0};
        cy = '{0, 0, 2, 0, 0, 1, 1, 0, 0, 1};
        cz = '{0, 0, 0, 2, 0, 0, 0, 1, 1, 1};
        for (int n = 0; n < 10; n++)
            load_node(4'(n), cx[n] * scale, cy[n] * scale, cz[n] * scale, pick_gap());
    endtask

    function automatic logic [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
        if (r < 9) return $urandom;
        return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    function automatic logic [16:0] rand_bary();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 17'($urandom_range(0, 65536));
        if (r < 8) return ($urandom_range(0, 1) != 0) ? 17'd65536 : 17'd0;
        return 17'($urandom);
    endfunction

    // Barycentric tuple that sums to one, the usual case in use.
    task automatic evaluate_inside(int gap);
        int a;
        int b;
        int c;
        a = $urandom_range(0, 65536);
        b = $urandom_range(0, 65536 - a);
        c = $urandom_range(0, 65536 - a - b);
        evaluate(17'(a), 17'(b), 17'(c), 17'(65536 - a - b - c), gap);
    endtask

    initial begin
        int items;
        int burst;
        sb          = new();
        hold_req    = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_mode      <= 1'b0;
        i_node_index <= '0;
        i_coord_x   <= '0;
        i_coord_y   <= '0;
        i_coord_z   <= '0;
        i_bary_one  <= '0;
        i_bary_two  <= '0;
        i_bary_three <= '0;
        i_bary_four <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: every node is loaded before any evaluation.
        load_unit_tet(65536);
        evaluate(17'd65536, 17'd0, 17'd0, 17'd0, 0);
        evaluate(17'd0, 17'd0, 17'd0, 17'd65536, pick_gap());
        evaluate(17'd16384, 17'd16384, 17'd16384, 17'd16384, 0);
        evaluate(17'd0, 17'd0, 17'd0, 17'd0, pick_gap());
        evaluate(17'd32768, 17'd32768, 17'd0, 17'd0, 0);
        // Barycentric values above one are used as given.
        evaluate(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, pick_gap());
        // Extreme coordinates drive the arithmetic into saturation.
        load_node(4'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        load_node(4'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        evaluate(17'd0, 17'd65536, 17'd65536, 17'd0, pick_gap());
        // An index above nine must leave the store untouched.
        load_node(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        load_node(4'd10, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 0);
        evaluate(17'd10000, 17'd20000, 17'd30000, 17'd5536, 0);

        items = 22;
        while (items < 230) begin
            // Long output hold-off while the sender keeps offering.
            if (items >= 70 && items < 75) hold_req = 1'b1;
            // Sender pause until every outstanding row has drained.
            if (items >= 140 && items < 145) begin
                i_in_valid <= 1'b0;
                while (sb.pending() > 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            if ($urandom_range(0, 9) < 7) begin
                burst = $urandom_range(0, 4);
                for (int k = 0; k < burst; k++) begin
                    load_node(($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                          : 4'($urandom_range(0, 9)),
                              rand_coord(), rand_coord(), rand_coord(), pick_gap());
                    items++;
                end
                evaluate_inside(pick_gap());
            end else if ($urandom_range(0, 1) != 0) begin
                evaluate(rand_bary(), rand_bary(), rand_bary(), rand_bary(), pick_gap());
            end else begin
                load_node(4'($urandom), $urandom, $urandom, $urandom, pick_gap());
            end
            items++;
        end
        i_in_valid <= 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/t10sf_pkg.sv
hw/rtl/t10sf_mul.sv
hw/rtl/t10sf_dpath.sv
hw/rtl/t10sf_ctrl.sv
hw/rtl/tet10_shape_function_eval_unit.sv
dv/tet10_shape_function_eval_unit_tb.sv
